@@ rtl/isotp_pkg.sv @@
// Shared types and constants for the ISO-TP frame reassembler.
`default_nettype none

package isotp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_VIOL       = 2'd1,
        ST_INCOMPLETE = 2'd2
    } status_t;

    localparam logic [3:0] FT_SINGLE = 4'h0;
    localparam logic [3:0] FT_FIRST  = 4'h1;
    localparam logic [3:0] FT_CONSEC = 4'h2;

    localparam logic [3:0] DLC_MAX      = 4'd8;
    localparam logic [2:0] FF_BYTES     = 3'd6;
    localparam logic [2:0] CF_MAX_BYTES = 3'd7;
    localparam logic [3:0] SEQ_START    = 4'd1;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef logic [6:0][7:0] payload_t;

    typedef struct packed {
        payload_t   data;
        logic [2:0] count;
        logic       has_status;
        status_t    status;
        logic [11:0] length;
    } job_t;

endpackage

`default_nettype wire

@@ rtl/isotp_frame_if.sv @@
// Input channel carrying one CAN frame per transfer.
`default_nettype none

interface isotp_frame_if;
    logic        valid;
    logic        ready;
    logic [63:0] frame_bytes;
    logic [3:0]  frame_length;
    logic        batch_end;

    modport source (output valid, output frame_bytes, output frame_length,
                    output batch_end, input ready);
    modport sink   (input valid, input frame_bytes, input frame_length,
                    input batch_end, output ready);
endinterface

`default_nettype wire

@@ rtl/isotp_result_if.sv @@
// Output channel carrying one payload byte or message status per transfer.
`default_nettype none

interface isotp_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  message_status;
    logic [11:0] message_length;
    logic        last_of_run;

    modport source (output valid, output result_kind, output payload_byte,
                    output message_status, output message_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input message_status, input message_length,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/isotp_front.sv @@
// Frame classifier: protocol state and job generation per accepted frame.
`default_nettype none

module isotp_front
    import isotp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    isotp_frame_if.sink  frames,
    output logic         push_valid,
    output job_t         push_job,
    input  wire logic    push_ready
);

    phase_t      phase_reg, phase_next;
    logic [11:0] total_reg, total_next;
    logic [12:0] received_reg, received_next;
    logic [3:0]  seq_reg, seq_next;

    logic        accept;
    logic [3:0]  dlc;
    logic [3:0]  tnib;
    logic [3:0]  lnib;
    logic        sf_bad;
    logic [11:0] ff_total;
    logic        ff_short;
    logic        ff_full;
    logic        ff_bad;
    logic [12:0] remaining;
    logic [2:0]  copy;
    logic        cf_bad;
    logic [12:0] cf_sum;
    logic        cf_done;
    job_t        job;

    assign accept = frames.valid && frames.ready;
    assign frames.ready = push_ready;

    assign dlc  = (frames.frame_length > DLC_MAX) ? DLC_MAX : frames.frame_length;
    assign tnib = frames.frame_bytes[63:60];
    assign lnib = frames.frame_bytes[59:56];

    assign sf_bad   = lnib >= dlc;
    assign ff_total = {lnib, frames.frame_bytes[55:48]};
    assign ff_short = ff_total < 12'(FF_BYTES);
    assign ff_full  = ff_total == 12'(FF_BYTES);
    assign ff_bad   = (tnib != FT_FIRST) || (dlc < DLC_MAX);

    assign remaining = {1'b0, total_reg} - received_reg;
    assign copy      = (remaining < 13'(CF_MAX_BYTES)) ? remaining[2:0] : CF_MAX_BYTES;
    assign cf_bad    = (dlc == 4'd0) || (tnib != FT_CONSEC) || (lnib != seq_reg)
                       || (dlc <= 4'(copy));
    assign cf_sum    = received_reg + 13'(copy);
    assign cf_done   = cf_sum == {1'b0, total_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        total_next    = total_reg;
        received_next = received_reg;
        seq_next      = seq_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if ((dlc == 4'd0) || (tnib == FT_SINGLE) || ff_bad)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        total_next = ff_total;
                        if (ff_short)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            received_next = 13'(FF_BYTES);
                            seq_next      = SEQ_START;
                            phase_next    = ff_full ? PH_DONE : PH_RECV;
                        end
                    end
                end
                PH_RECV:
                begin
                    if (cf_bad)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        received_next = cf_sum;
                        seq_next      = seq_reg + 4'd1;
                        if (cf_done)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (frames.batch_end)
            begin
                phase_next    = PH_IDLE;
                total_next    = '0;
                received_next = '0;
                seq_next      = SEQ_START;
            end
        end
    end

    always_comb
    begin
        job            = '0;
        job.data       = frames.frame_bytes[55:0];
        job.status     = ST_OK;
        case (phase_reg)
            PH_IDLE:
            begin
                if (dlc == 4'd0)
                begin
                    job.has_status = 1'b1;
                    job.status     = ST_VIOL;
                end
                else if (tnib == FT_SINGLE)
                begin
                    job.has_status = 1'b1;
                    job.length     = {8'h00, lnib};
                    if (sf_bad)
                    begin
                        job.status = ST_VIOL;
                    end
                    else
                    begin
                        job.count = lnib[2:0];
                    end
                end
                else if (ff_bad)
                begin
                    job.has_status = 1'b1;
                    job.status     = ST_VIOL;
                end
                else if (ff_short)
                begin
                    job.has_status = 1'b1;
                    job.status     = ST_INCOMPLETE;
                    job.length     = ff_total;
                end
                else
                begin
                    job.count  = FF_BYTES;
                    job.data   = {frames.frame_bytes[47:0], 8'h00};
                    job.length = ff_total;
                    if (ff_full)
                    begin
                        job.has_status = 1'b1;
                    end
                    else if (frames.batch_end)
                    begin
                        job.has_status = 1'b1;
                        job.status     = ST_INCOMPLETE;
                    end
                end
            end
            PH_RECV:
            begin
                job.length = total_reg;
                if (cf_bad)
                begin
                    job.has_status = 1'b1;
                    job.status     = ST_VIOL;
                end
                else
                begin
                    job.count = copy;
                    if (cf_done)
                    begin
                        job.has_status = 1'b1;
                    end
                    else if (frames.batch_end)
                    begin
                        job.has_status = 1'b1;
                        job.status     = ST_INCOMPLETE;
                    end
                end
            end
            default:
            begin
                job.count = 3'd0;
            end
        endcase
    end

    assign push_valid = accept && ((job.count != 3'd0) || job.has_status);
    assign push_job   = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            total_reg    <= '0;
            received_reg <= '0;
            seq_reg      <= SEQ_START;
        end
        else
        begin
            phase_reg    <= phase_next;
            total_reg    <= total_next;
            received_reg <= received_next;
            seq_reg      <= seq_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/isotp_queue.sv @@
// Small job queue between the classifier and the result sequencer.
`default_nettype none

module isotp_queue
    import isotp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    input  wire job_t  push_job,
    output logic       push_ready,
    output logic       pop_valid,
    output job_t       pop_job,
    input  wire logic  pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t           entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ rtl/isotp_back.sv @@
// Result sequencer: expands one job into payload bytes and, when the job carries one, a status.
`default_nettype none

module isotp_back
    import isotp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      pop_valid,
    input  wire job_t      pop_job,
    output logic           pop_ready,
    isotp_result_if.source results
);

    job_t        cur_reg;
    logic        cur_valid_reg, cur_valid_next;
    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [7:0]  byte_reg;
    logic [1:0]  status_reg;
    logic [11:0] length_reg;
    logic        last_reg;

    logic        advance;
    logic        emit;
    logic        is_byte;
    logic        last_byte;
    logic        finish;
    logic        load;
    logic [7:0]  byte_sel;

    assign advance   = !out_valid_reg || results.ready;
    assign emit      = advance && cur_valid_reg;
    assign is_byte   = idx_reg < cur_reg.count;
    assign last_byte = idx_reg == (cur_reg.count - 3'd1);
    assign finish    = emit && (!is_byte || (last_byte && !cur_reg.has_status));
    assign pop_ready = !cur_valid_reg || finish;
    assign load      = pop_valid && pop_ready;
    assign byte_sel  = cur_reg.data[3'd6 - idx_reg];

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
        else
        begin
            if (finish)
            begin
                cur_valid_next = 1'b0;
            end
            if (emit && is_byte)
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= pop_job;
        end
        if (emit)
        begin
            if (is_byte)
            begin
                kind_reg   <= KIND_BYTE;
                byte_reg   <= byte_sel;
                status_reg <= 2'd0;
                length_reg <= '0;
                last_reg   <= last_byte && !cur_reg.has_status;
            end
            else
            begin
                kind_reg   <= KIND_STATUS;
                byte_reg   <= 8'h00;
                status_reg <= cur_reg.status;
                length_reg <= cur_reg.length;
                last_reg   <= 1'b1;
            end
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.result_kind    = kind_reg;
    assign results.payload_byte   = byte_reg;
    assign results.message_status = status_reg;
    assign results.message_length = length_reg;
    assign results.last_of_run    = last_reg;

endmodule

`default_nettype wire

@@ rtl/isotp_frame_reassembler_core.sv @@
// Path: the first result of a frame passes the job queue, the sequencer's job register and the output register.
// Throughput: one frame per cycle while the job queue has room; a frame that
//   yields n results (up to eight) holds the result port until all n are taken.
// Ignored frames produce no result.
// Reset: rst_n clears the protocol state, the job queue and the output register.
`default_nettype none

module isotp_frame_reassembler_core
    import isotp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    isotp_frame_if.sink    frames,
    isotp_result_if.source results
);

    logic push_valid;
    job_t push_job;
    logic push_ready;
    logic pop_valid;
    job_t pop_job;
    logic pop_ready;

    isotp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frames     (frames),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    isotp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop_ready  (pop_ready)
    );

    isotp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_job   (pop_job),
        .pop_ready (pop_ready),
        .results   (results)
    );

`ifndef ASSERT_OFF
    a_status_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.result_kind == KIND_STATUS) |-> results.last_of_run)
        else $error("status result without last_of_run");

    a_byte_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.result_kind == KIND_BYTE)
        |-> (results.message_status == 2'd0) && (results.message_length == 12'd0))
        else $error("payload result carries status fields");

    a_pop_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |-> (pop_job.count != 3'd0) || pop_job.has_status)
        else $error("empty job reached the sequencer");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_isotp_frame_reassembler_core.sv @@
// Self-checking testbench for the ISO-TP frame reassembler core.
module tb_isotp_frame_reassembler_core;
    import isotp_pkg::*;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  dlc;
        logic        batch_end;
    } can_frame_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload;
        logic [1:0]  status;
        logic [11:0] length;
        logic        last;
    } outcome_t;

    logic clk;
    logic rst_n;

    isotp_frame_if  frames_bus();
    isotp_result_if results_bus();

    isotp_frame_reassembler_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .frames  (frames_bus),
        .results (results_bus)
    );

    can_frame_t  pending_frames[$];
    outcome_t    awaited_results[$];
    outcome_t    produced[$];
    int unsigned frame_total;
    int unsigned frames_taken;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned error_count;
    int unsigned payload_seen;
    int unsigned status_tally[3];
    outcome_t    seen;
    outcome_t    want;

    phase_t      rx_phase = PH_IDLE;
    logic [11:0] rx_total = 12'd0;
    logic [12:0] rx_count = 13'd0;
    logic [3:0]  rx_seq   = SEQ_START;

    assign send_idle_pct = (frames_taken < frame_total / 3) ? 23 :
                           (frames_taken < 2 * frame_total / 3) ? 70 : 0;
    assign recv_idle_pct = (frames_taken < frame_total / 3) ? 70 :
                           (frames_taken < 2 * frame_total / 3) ? 23 : 0;

    function automatic logic [7:0] byte_at(logic [63:0] data, int unsigned idx);
        return data[63 - 8 * idx -: 8];
    endfunction

    function automatic outcome_t byte_outcome(logic [7:0] value);
        outcome_t o;
        o = '0;
        o.kind = KIND_BYTE;
        o.payload = value;
        return o;
    endfunction

    function automatic outcome_t status_outcome(status_t st, logic [11:0] len);
        outcome_t o;
        o = '0;
        o.kind = KIND_STATUS;
        o.status = st;
        o.length = len;
        return o;
    endfunction

    task automatic add_result(input outcome_t o);
        produced.insert(produced.size(), o);
    endtask

    task automatic reassemble_frame(input can_frame_t f);
        logic [3:0]  used_len;
        logic [7:0]  head;
        logic [12:0] remaining;
        int unsigned take;
        int unsigned i;
        produced.delete();
        used_len = (f.dlc > DLC_MAX) ? DLC_MAX : f.dlc;
        head = byte_at(f.data, 0);
        case (rx_phase)
            PH_IDLE:
            begin
                if (used_len == 4'd0)
                begin
                    add_result(status_outcome(ST_VIOL, 12'd0));
                    rx_phase = PH_DONE;
                end
                else if (head[7:4] == FT_SINGLE)
                begin
                    if (head[3:0] > used_len - 4'd1)
                        add_result(status_outcome(ST_VIOL, {8'd0, head[3:0]}));
                    else
                    begin
                        for (i = 1; i <= head[3:0]; i++)
                            add_result(byte_outcome(byte_at(f.data, i)));
                        add_result(status_outcome(ST_OK, {8'd0, head[3:0]}));
                    end
                    rx_phase = PH_DONE;
                end
                else if (head[7:4] != FT_FIRST || used_len < DLC_MAX)
                begin
                    add_result(status_outcome(ST_VIOL, 12'd0));
                    rx_phase = PH_DONE;
                end
                else
                begin
                    rx_total = {head[3:0], byte_at(f.data, 1)};
                    if (rx_total < FF_BYTES)
                    begin
                        add_result(status_outcome(ST_INCOMPLETE, rx_total));
                        rx_phase = PH_DONE;
                    end
                    else
                    begin
                        for (i = 2; i < 8; i++)
                            add_result(byte_outcome(byte_at(f.data, i)));
                        rx_count = 13'(FF_BYTES);
                        rx_seq = SEQ_START;
                        if (rx_count == rx_total)
                        begin
                            add_result(status_outcome(ST_OK, rx_total));
                            rx_phase = PH_DONE;
                        end
                        else
                        begin
                            rx_phase = PH_RECV;
                            if (f.batch_end)
                                add_result(status_outcome(ST_INCOMPLETE, rx_total));
                        end
                    end
                end
            end
            PH_RECV:
            begin
                remaining = {1'b0, rx_total} - rx_count;
                take = (remaining < CF_MAX_BYTES) ? remaining : CF_MAX_BYTES;
                if (used_len == 4'd0 || head[7:4] != FT_CONSEC || head[3:0] != rx_seq
                    || used_len < take + 1)
                begin
                    add_result(status_outcome(ST_VIOL, rx_total));
                    rx_phase = PH_DONE;
                end
                else
                begin
                    for (i = 1; i <= take; i++)
                        add_result(byte_outcome(byte_at(f.data, i)));
                    rx_count = rx_count + 13'(take);
                    rx_seq = rx_seq + 4'd1;
                    if (rx_count == rx_total)
                    begin
                        add_result(status_outcome(ST_OK, rx_total));
                        rx_phase = PH_DONE;
                    end
                    else if (f.batch_end)
                        add_result(status_outcome(ST_INCOMPLETE, rx_total));
                end
            end
            default:
            begin
            end
        endcase
        if (produced.size() > 0)
            produced[produced.size() - 1].last = 1'b1;
        foreach (produced[j])
            awaited_results.insert(awaited_results.size(), produced[j]);
        if (f.batch_end)
        begin
            rx_phase = PH_IDLE;
            rx_total = 12'd0;
            rx_count = 13'd0;
            rx_seq = SEQ_START;
        end
    endtask

    function automatic logic [63:0] random_bytes();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_frame(logic [63:0] data, int unsigned len, logic closes);
        can_frame_t f;
        f.data = data;
        f.dlc = len[3:0];
        f.batch_end = closes;
        pending_frames.insert(pending_frames.size(), f);
    endtask

    task automatic queue_single(int unsigned sf_len, int unsigned len, logic closes);
        logic [63:0] d;
        d = random_bytes();
        d[63:56] = {FT_SINGLE, sf_len[3:0]};
        queue_frame(d, len, closes);
    endtask

    task automatic queue_first(int unsigned total, int unsigned len, logic closes);
        logic [63:0] d;
        d = random_bytes();
        d[63:56] = {FT_FIRST, total[11:8]};
        d[55:48] = total[7:0];
        queue_frame(d, len, closes);
    endtask

    task automatic queue_consec(logic [3:0] ftype, logic [3:0] seq, int unsigned len,
                                logic closes);
        logic [63:0] d;
        d = random_bytes();
        d[63:56] = {ftype, seq};
        queue_frame(d, len, closes);
    endtask

    task automatic queue_multi_message();
        int unsigned total;
        int unsigned ncf;
        int unsigned last_idx;
        int unsigned bad_idx;
        int unsigned junk;
        int unsigned pick;
        int unsigned copy;
        int unsigned len;
        int unsigned j;
        logic [3:0]  seq;
        logic [3:0]  ftype;
        logic        closes;
        pick = $urandom_range(99);
        if (pick < 60)
            total = $urandom_range(7, 40);
        else if (pick < 85)
            total = $urandom_range(41, 130);
        else if (pick < 93)
            total = 6;
        else
            total = $urandom_range(131, 4095);
        ncf = total / 7;
        last_idx = ncf;
        bad_idx = ncf + 1;
        junk = $urandom_range(0, 2);
        pick = $urandom_range(99);
        if (total > 130)
        begin
            last_idx = $urandom_range(0, 3);
            junk = 0;
        end
        else if (ncf > 0 && pick < 12)
        begin
            last_idx = $urandom_range(0, ncf - 1);
            junk = 0;
        end
        else if (ncf > 0 && pick < 30)
        begin
            bad_idx = $urandom_range(1, ncf);
            last_idx = bad_idx;
        end
        for (j = 0; j <= last_idx; j++)
        begin
            closes = (j == last_idx) && (junk == 0);
            if (j == 0)
                queue_first(total, ($urandom_range(9) == 0) ? $urandom_range(9, 15) : 8,
                            closes);
            else
            begin
                copy = total - 6 - 7 * (j - 1);
                if (copy > 7)
                    copy = 7;
                len = ($urandom_range(4) == 0) ? $urandom_range(copy + 1, 15)
                                              : $urandom_range(copy + 1, 8);
                seq = j[3:0];
                ftype = FT_CONSEC;
                if (j == bad_idx)
                    case ($urandom_range(3))
                        0: seq = seq + 4'($urandom_range(1, 15));
                        1: ftype = FT_CONSEC ^ 4'($urandom_range(1, 15));
                        2: len = $urandom_range(1, copy);
                        default: len = 0;
                    endcase
                queue_consec(ftype, seq, len, closes);
            end
        end
        for (j = 0; j < junk; j++)
            queue_frame(random_bytes(), $urandom_range(0, 15), j == junk - 1);
    endtask

    task automatic queue_single_batch();
        int unsigned sf_len;
        int unsigned len;
        logic        closes;
        if ($urandom_range(3) != 0)
        begin
            sf_len = $urandom_range(0, 7);
            len = $urandom_range(sf_len + 1, 8);
        end
        else
        begin
            sf_len = $urandom_range(0, 15);
            len = $urandom_range(0, 15);
        end
        closes = ($urandom_range(3) != 0);
        queue_single(sf_len, len, closes);
        if (!closes)
            queue_frame(random_bytes(), $urandom_range(0, 15), 1'b1);
    endtask

    task automatic compare_field(string name, logic [11:0] expected, logic [11:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expected, actual);
            error_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Drive frames; predict on every transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_bus.valid <= 1'b0;
            frames_bus.frame_bytes <= 64'd0;
            frames_bus.frame_length <= 4'd0;
            frames_bus.batch_end <= 1'b0;
        end
        else
        begin
            if (frames_bus.valid && frames_bus.ready)
            begin
                reassemble_frame({frames_bus.frame_bytes, frames_bus.frame_length,
                                  frames_bus.batch_end});
                frames_taken <= frames_taken + 1;
            end
            if (!frames_bus.valid || frames_bus.ready)
            begin
                if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    frames_bus.frame_bytes <= pending_frames[0].data;
                    frames_bus.frame_length <= pending_frames[0].dlc;
                    frames_bus.batch_end <= pending_frames[0].batch_end;
                    frames_bus.valid <= 1'b1;
                    void'(pending_frames.pop_front());
                end
                else
                    frames_bus.valid <= 1'b0;
            end
        end
    end

    // Check each result transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_bus.ready <= 1'b0;
        else
        begin
            if (results_bus.valid && results_bus.ready)
            begin
                seen.kind = results_bus.result_kind;
                seen.payload = results_bus.payload_byte;
                seen.status = results_bus.message_status;
                seen.length = results_bus.message_length;
                seen.last = results_bus.last_of_run;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, seen);
                    error_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("result_kind", want.kind, seen.kind);
                    compare_field("payload_byte", want.payload, seen.payload);
                    compare_field("message_status", want.status, seen.status);
                    compare_field("message_length", want.length, seen.length);
                    compare_field("last_of_run", want.last, seen.last);
                    if (want.kind == KIND_STATUS && want.status <= ST_INCOMPLETE)
                        status_tally[want.status]++;
                    else
                        payload_seen++;
                end
            end
            results_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        frames_bus.valid = 1'b0;
        frames_bus.frame_bytes = 64'd0;
        frames_bus.frame_length = 4'd0;
        frames_bus.batch_end = 1'b0;
        results_bus.ready = 1'b0;
        frames_taken = 0;
        error_count = 0;
        payload_seen = 0;
        status_tally = '{0, 0, 0};

        queue_single(0, 1, 1'b1);
        queue_single(7, 8, 1'b1);
        queue_single(5, 4, 1'b1);
        queue_frame(64'd0, 0, 1'b1);
        queue_frame({FT_SINGLE, 4'd7, {56{1'b1}}}, 15, 1'b1);
        queue_frame({64{1'b1}}, 8, 1'b1);
        queue_first(40, 7, 1'b1);
        queue_first(3, 8, 1'b0);
        queue_consec(FT_CONSEC, 4'd1, 8, 1'b1);
        queue_first(6, 8, 1'b1);
        queue_first(25, 8, 1'b0);
        queue_consec(FT_CONSEC, 4'd1, 8, 1'b0);
        queue_consec(FT_CONSEC, 4'd2, 8, 1'b0);
        queue_consec(FT_CONSEC, 4'd3, 6, 1'b1);
        queue_first(20, 8, 1'b0);
        queue_consec(FT_CONSEC, 4'd1, 8, 1'b1);
        queue_first(4095, 8, 1'b1);
        queue_first(10, 8, 1'b0);
        queue_consec(FT_CONSEC, 4'd2, 8, 1'b0);
        queue_consec(FT_CONSEC, 4'd1, 8, 1'b1);
        queue_first(10, 8, 1'b0);
        queue_consec(FT_CONSEC, 4'd1, 4, 1'b1);
        queue_first(10, 8, 1'b0);
        queue_consec(FT_CONSEC, 4'd1, 0, 1'b1);
        queue_consec(FT_CONSEC, 4'd1, 8, 1'b1);

        frame_total = 480;
        while (pending_frames.size() < frame_total)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: queue_multi_message();
                11, 12, 13, 14: queue_single_batch();
                15, 16:
                    if ($urandom_range(1))
                        queue_first($urandom_range(0, 5), $urandom_range(8, 15), 1'b1);
                    else
                        queue_first($urandom_range(0, 4095), $urandom_range(1, 7), 1'b1);
                default: queue_frame(random_bytes(), $urandom_range(0, 15),
                                     1'($urandom_range(1)));
            endcase
        end
        frame_total = pending_frames.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_frames.size() != 0 || frames_bus.valid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d CAN frames under three idle mixes; checked %0d payload bytes.",
                 frames_taken, payload_seen);
        $display("Closed messages: %0d ok, %0d protocol violation, %0d incomplete.",
                 status_tally[0], status_tally[1], status_tally[2]);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timed out with %0d frames pending and %0d results awaited.",
                 pending_frames.size(), awaited_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
